FILE: rtl/lbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lbc_pkg;

   // Widths fixed by the coordinate format and the window registers.
   localparam int unsigned COORD_WIDTH  = 32;
   localparam int unsigned WINDOW_WIDTH = 31;

   // Integer part of the line parameter limit (1e8) and the bits it needs.
   localparam int unsigned LIMIT_BITS = 27;
   localparam logic [LIMIT_BITS-1:0] LINE_T_LIMIT = 27'd100000000;

   // Default number of fraction bits of the line parameter t.
   localparam int unsigned PARAM_FRAC_BITS_DEFAULT = 28;

   typedef enum logic [0:0] {
      CSR_HALF_WIDTH  = 1'b0,
      CSR_HALF_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] start_x;
      logic signed [COORD_WIDTH-1:0] start_y;
      logic signed [COORD_WIDTH-1:0] end_x;
      logic signed [COORD_WIDTH-1:0] end_y;
      logic                          segment_mode;
   } req_payload_type;

   typedef struct packed {
      logic                          visible;
      logic signed [COORD_WIDTH-1:0] clipped_start_x;
      logic signed [COORD_WIDTH-1:0] clipped_start_y;
      logic signed [COORD_WIDTH-1:0] clipped_end_x;
      logic signed [COORD_WIDTH-1:0] clipped_end_y;
   } rsp_payload_type;

   // Sign and zero information of one edge test, passed alongside its ratio.
   typedef struct packed {
      logic pzero;
      logic pneg;
      logic qneg;
   } edge_flags_type;

endpackage

`default_nettype wire

FILE: rtl/lbc_ratio_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider: one quotient bit per stage, clamped ratio q/p.
module lbc_ratio_div #(
   parameter int unsigned PARAM_FRAC_BITS = lbc_pkg::PARAM_FRAC_BITS_DEFAULT
) (
   input  wire logic                                                     clock,
   input  wire logic                                                     enable,
   input  wire logic signed [33:0]                                       p_in,
   input  wire logic signed [33:0]                                       q_in,
   output logic signed [lbc_pkg::LIMIT_BITS+PARAM_FRAC_BITS:0]          ratio_out,
   output lbc_pkg::edge_flags_type                                       flags_out
);

   localparam int unsigned MW = 33;
   localparam int unsigned RW = MW + 1;
   localparam int unsigned QW = lbc_pkg::LIMIT_BITS + PARAM_FRAC_BITS;
   localparam int unsigned TW = QW + 1;
   localparam logic [QW-1:0] CLAMP_MAG =
      ({{(QW-lbc_pkg::LIMIT_BITS){1'b0}}, lbc_pkg::LINE_T_LIMIT} + {{(QW-1){1'b0}}, 1'b1})
      << PARAM_FRAC_BITS;

   typedef struct packed {
      logic [RW-1:0]           rem;
      logic [MW-1:0]           num;
      logic [MW-1:0]           den;
      logic [QW-1:0]           quo;
      logic                    ovf;
      lbc_pkg::edge_flags_type flags;
   } div_stage_type;

   div_stage_type stage_ff [0:QW];
   div_stage_type stage_in [0:QW];
   logic signed [TW-1:0] ratio_ff, ratio_in;
   lbc_pkg::edge_flags_type flags_ff;

   logic signed [33:0] q_neg, p_neg;
   logic [MW-1:0]      num_mag, den_mag;

   always_comb begin
      q_neg   = -q_in;
      p_neg   = -p_in;
      num_mag = q_in[33] ? q_neg[MW-1:0] : q_in[MW-1:0];
      den_mag = p_in[33] ? p_neg[MW-1:0] : p_in[MW-1:0];
      stage_in[0].num         = num_mag;
      stage_in[0].den         = den_mag;
      stage_in[0].quo         = '0;
      // The quotient cannot fit below 2^QW once num >> LIMIT_BITS reaches den.
      stage_in[0].ovf = {{lbc_pkg::LIMIT_BITS{1'b0}}, num_mag[MW-1:lbc_pkg::LIMIT_BITS]}
                        >= den_mag;
      stage_in[0].rem = {{(RW-MW+lbc_pkg::LIMIT_BITS){1'b0}},
                         num_mag[MW-1:lbc_pkg::LIMIT_BITS]};
      stage_in[0].flags.pzero = (p_in == '0);
      stage_in[0].flags.pneg  = p_in[33];
      stage_in[0].flags.qneg  = q_in[33];
   end

   genvar k;
   generate
      for (k = 1; k <= QW; k++) begin : g_bit
         localparam int unsigned J = QW - k;
         logic          nb;
         logic [RW-1:0] trial;
         logic          ge;
         if (J >= PARAM_FRAC_BITS) begin : g_num
            assign nb = stage_ff[k-1].num[J-PARAM_FRAC_BITS];
         end else begin : g_zero
            assign nb = 1'b0;
         end
         always_comb begin
            trial = {stage_ff[k-1].rem[RW-2:0], nb};
            ge    = trial >= {1'b0, stage_ff[k-1].den};
            stage_in[k]        = stage_ff[k-1];
            stage_in[k].rem    = ge ? trial - {1'b0, stage_ff[k-1].den} : trial;
            stage_in[k].quo[J] = ge;
         end
      end
   endgenerate

   always_comb begin
      logic [QW-1:0] mag;
      mag = (stage_ff[QW].ovf || stage_ff[QW].quo >= CLAMP_MAG) ? CLAMP_MAG
                                                                 : stage_ff[QW].quo;
      ratio_in = (stage_ff[QW].flags.qneg ^ stage_ff[QW].flags.pneg)
                 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i <= QW; i++) begin
            stage_ff[i] <= stage_in[i];
         end
         ratio_ff <= ratio_in;
         flags_ff <= stage_ff[QW].flags;
      end
   end

   assign ratio_out = ratio_ff;
   assign flags_out = flags_ff;

endmodule

`default_nettype wire

FILE: rtl/liang_barsky_line_clipper.sv
`timescale 1ns / 1ps
`default_nettype none

// Liang-Barsky clipper for lines and segments against a centred window of half extents
// window_half_width and window_half_height (Q16.16, written through the csr_ port while no
// transaction is in flight). Each request transaction gives exactly one response transaction,
// in order. The pipeline takes one transaction every cycle while its skid register is empty. It
// holds an input stage, then the four restoring dividers that resolve one quotient bit per stage,
// followed by two stages of edge tests, one of parameter magnitudes, one of partial products, one
// to combine them, one to round and one to offset and saturate. A skid register after the output
// stage holds a response that is not taken at once, so the pipeline advances whenever that
// register is empty and stalls without losing or repeating anything. An invisible line returns
// zero for all four endpoints.

module liang_barsky_line_clipper #(
   parameter int unsigned PARAM_FRAC_BITS = lbc_pkg::PARAM_FRAC_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire lbc_pkg::req_payload_type              req_payload,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output lbc_pkg::rsp_payload_type                   rsp_payload,
   input  wire logic                                  csr_write_enable,
   input  wire lbc_pkg::csr_index_type                csr_index,
   input  wire logic [lbc_pkg::WINDOW_WIDTH-1:0]      csr_write_data
);

   localparam int unsigned QW      = lbc_pkg::LIMIT_BITS + PARAM_FRAC_BITS;
   localparam int unsigned TW      = QW + 1;
   localparam int unsigned DIV_LAT = QW + 2;
   localparam int unsigned PW      = QW + 32;
   localparam int unsigned OW      = PW + 1 - PARAM_FRAC_BITS;
   localparam logic signed [TW-1:0] T_LIM =
      $signed({{(TW-lbc_pkg::LIMIT_BITS){1'b0}}, lbc_pkg::LINE_T_LIMIT} << PARAM_FRAC_BITS);
   localparam logic signed [TW-1:0] T_ONE = $signed({{(TW-1){1'b0}}, 1'b1} << PARAM_FRAC_BITS);
   localparam logic [PW:0] RND = {{PW{1'b0}}, 1'b1} << (PARAM_FRAC_BITS - 1);
   localparam logic [PW:0] RND_NEG = RND + {{PW{1'b0}}, 1'b1};

   typedef struct packed {
      logic signed [31:0] x1;
      logic signed [31:0] y1;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic               segment_mode;
   } side_type;

   typedef struct packed {
      logic signed [TW-1:0] t0;
      logic signed [TW-1:0] t1;
      logic                 ok;
   } edge_state_type;

   typedef struct packed {
      edge_state_type          es;
      side_type                side;
      logic signed [TW-1:0]    r2;
      logic signed [TW-1:0]    r3;
      lbc_pkg::edge_flags_type f2;
      lbc_pkg::edge_flags_type f3;
   } edge1_type;

   typedef struct packed {
      edge_state_type es;
      side_type       side;
   } edge2_type;

   function automatic edge_state_type edge_step(input edge_state_type s,
                                                input logic signed [TW-1:0] r,
                                                input lbc_pkg::edge_flags_type f);
      edge_state_type n;
      n = s;
      if (f.pzero) begin
         if (f.qneg) n.ok = 1'b0;
      end else if (f.pneg) begin
         if (r > s.t1) n.ok = 1'b0;
         else if (r > s.t0) n.t0 = r;
      end else begin
         if (r < s.t0) n.ok = 1'b0;
         else if (r < s.t1) n.t1 = r;
      end
      return n;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [OW:0] v);
      logic signed [31:0] res;
      if ((&v[OW:31]) || !(|v[OW:31])) res = v[31:0];
      else if (v[OW]) res = 32'sh8000_0000;
      else res = 32'sh7fff_ffff;
      return res;
   endfunction

   logic adv;

   // Window registers.
   logic [lbc_pkg::WINDOW_WIDTH-1:0] half_w_ff, half_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_w_ff <= 31'd65536;
         half_h_ff <= 31'd65536;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lbc_pkg::CSR_HALF_WIDTH:  half_w_ff <= csr_write_data;
            lbc_pkg::CSR_HALF_HEIGHT: half_h_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Input stage.
   lbc_pkg::req_payload_type s1_ff;
   logic                     s1_vld_ff;

   // Edge set-up from the input stage: p and q of the four window edges.
   logic signed [33:0] x1e, y1e, wz, hz;
   logic signed [32:0] dx, dy;
   logic signed [33:0] p_edge [0:3];
   logic signed [33:0] q_edge [0:3];
   side_type           side_in;

   always_comb begin
      x1e = {{2{s1_ff.start_x[31]}}, s1_ff.start_x};
      y1e = {{2{s1_ff.start_y[31]}}, s1_ff.start_y};
      wz  = {3'b000, half_w_ff};
      hz  = {3'b000, half_h_ff};
      dx  = {s1_ff.end_x[31], s1_ff.end_x} - {s1_ff.start_x[31], s1_ff.start_x};
      dy  = {s1_ff.end_y[31], s1_ff.end_y} - {s1_ff.start_y[31], s1_ff.start_y};
      p_edge[0] = -{dx[32], dx};
      q_edge[0] = x1e + wz;
      p_edge[1] = {dx[32], dx};
      q_edge[1] = wz - x1e;
      p_edge[2] = -{dy[32], dy};
      q_edge[2] = y1e + hz;
      p_edge[3] = {dy[32], dy};
      q_edge[3] = hz - y1e;
      side_in.x1           = s1_ff.start_x;
      side_in.y1           = s1_ff.start_y;
      side_in.dx           = dx;
      side_in.dy           = dy;
      side_in.segment_mode = s1_ff.segment_mode;
   end

   logic signed [TW-1:0]    ratio [0:3];
   lbc_pkg::edge_flags_type flags [0:3];

   genvar e;
   generate
      for (e = 0; e < 4; e++) begin : g_div
         lbc_ratio_div #(
            .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
         ) u_div (
            .clock     (clock),
            .enable    (adv),
            .p_in      (p_edge[e]),
            .q_in      (q_edge[e]),
            .ratio_out (ratio[e]),
            .flags_out (flags[e])
         );
      end
   endgenerate

   // Side data delayed to meet the divider results.
   side_type side_ff     [0:DIV_LAT-1];
   logic     side_vld_ff [0:DIV_LAT-1];

   // Edge tests, two per stage.
   edge1_type e1_ff, e1_in;
   logic      e1_vld_ff;
   edge2_type e2_ff, e2_in;
   logic      e2_vld_ff;

   always_comb begin
      edge_state_type s;
      s.ok = 1'b1;
      if (side_ff[DIV_LAT-1].segment_mode) begin
         s.t0 = '0;
         s.t1 = T_ONE;
      end else begin
         s.t0 = -T_LIM;
         s.t1 = T_LIM;
      end
      s = edge_step(s, ratio[0], flags[0]);
      e1_in.es   = edge_step(s, ratio[1], flags[1]);
      e1_in.side = side_ff[DIV_LAT-1];
      e1_in.r2   = ratio[2];
      e1_in.r3   = ratio[3];
      e1_in.f2   = flags[2];
      e1_in.f3   = flags[3];
   end

   always_comb begin
      edge_state_type s;
      s = edge_step(e1_ff.es, e1_ff.r2, e1_ff.f2);
      e2_in.es   = edge_step(s, e1_ff.r3, e1_ff.f3);
      e2_in.side = e1_ff.side;
   end

   // Point arithmetic: the four products are t0*dx, t0*dy, t1*dx and t1*dy.
   logic [QW-1:0]      tm_ff    [0:3];
   logic [31:0]        dm_ff    [0:3];
   logic               neg_ff   [0:3];
   logic signed [31:0] base_ff  [0:3];
   logic               mg_vis_ff, mg_vld_ff;

   logic [QW-1:0]      tm_in    [0:3];
   logic [31:0]        dm_in    [0:3];
   logic               neg_in   [0:3];
   logic signed [31:0] base_in  [0:3];

   always_comb begin
      logic signed [TW-1:0] t_sel;
      logic signed [32:0]   d_sel;
      logic signed [TW-1:0] t_neg;
      logic signed [32:0]   d_neg;
      for (int i = 0; i < 4; i++) begin
         t_sel = (i < 2) ? e2_ff.es.t0 : e2_ff.es.t1;
         d_sel = (i % 2 == 0) ? e2_ff.side.dx : e2_ff.side.dy;
         t_neg = -t_sel;
         d_neg = -d_sel;
         tm_in[i]   = t_sel[TW-1] ? t_neg[QW-1:0] : t_sel[QW-1:0];
         dm_in[i]   = d_sel[32] ? d_neg[31:0] : d_sel[31:0];
         neg_in[i]  = t_sel[TW-1] ^ d_sel[32];
         base_in[i] = (i % 2 == 0) ? e2_ff.side.x1 : e2_ff.side.y1;
      end
   end

   logic [63:0]      lo_ff   [0:3];
   logic [QW-1:0]    hi_ff   [0:3];
   logic             pp_neg_ff [0:3];
   logic signed [31:0] pp_base_ff [0:3];
   logic             pp_vis_ff, pp_vld_ff;

   logic [PW-1:0]    mag_ff  [0:3];
   logic             cm_neg_ff [0:3];
   logic signed [31:0] cm_base_ff [0:3];
   logic             cm_vis_ff, cm_vld_ff;

   logic [PW:0]      rd_ff   [0:3];
   logic signed [31:0] rd_base_ff [0:3];
   logic             rd_vis_ff, rd_vld_ff;

   lbc_pkg::rsp_payload_type out_ff, out_in;
   logic                     out_vld_ff;
   lbc_pkg::rsp_payload_type skid_ff;
   logic                     skid_full_ff;

   always_comb begin
      logic signed [OW:0] sum [0:3];
      logic signed [31:0] pt  [0:3];
      for (int i = 0; i < 4; i++) begin
         sum[i] = {{(OW-31){rd_base_ff[i][31]}}, rd_base_ff[i]}
                + {rd_ff[i][PW], rd_ff[i][PW:PARAM_FRAC_BITS]};
         pt[i]  = rd_vis_ff ? sat32(sum[i]) : '0;
      end
      out_in.visible         = rd_vis_ff;
      out_in.clipped_start_x = pt[0];
      out_in.clipped_start_y = pt[1];
      out_in.clipped_end_x   = pt[2];
      out_in.clipped_end_y   = pt[3];
   end

   // The whole pipeline moves together while the skid register is free. No request is taken
   // while reset is held, since the valid bits are being cleared.
   assign adv       = !skid_full_ff;
   assign req_ready = adv && !reset;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff      <= req_payload;
         side_ff[0] <= side_in;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         e1_ff <= e1_in;
         e2_ff <= e2_in;
         mg_vis_ff <= e2_ff.es.ok && (e2_ff.es.t0 <= e2_ff.es.t1);
         pp_vis_ff <= mg_vis_ff;
         cm_vis_ff <= pp_vis_ff;
         rd_vis_ff <= cm_vis_ff;
         for (int i = 0; i < 4; i++) begin
            tm_ff[i]      <= tm_in[i];
            dm_ff[i]      <= dm_in[i];
            neg_ff[i]     <= neg_in[i];
            base_ff[i]    <= base_in[i];
            lo_ff[i]      <= tm_ff[i][31:0] * dm_ff[i];
            hi_ff[i]      <= tm_ff[i][QW-1:32] * dm_ff[i];
            pp_neg_ff[i]  <= neg_ff[i];
            pp_base_ff[i] <= base_ff[i];
            mag_ff[i]     <= {hi_ff[i], 32'b0} + {{(PW-64){1'b0}}, lo_ff[i]};
            cm_neg_ff[i]  <= pp_neg_ff[i];
            cm_base_ff[i] <= pp_base_ff[i];
            // Round to nearest with halves upwards, on the signed product.
            rd_ff[i]      <= cm_neg_ff[i] ? ~{1'b0, mag_ff[i]} + RND_NEG
                                          : {1'b0, mag_ff[i]} + RND;
            rd_base_ff[i] <= cm_base_ff[i];
         end
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         e1_vld_ff  <= 1'b0;
         e2_vld_ff  <= 1'b0;
         mg_vld_ff  <= 1'b0;
         pp_vld_ff  <= 1'b0;
         cm_vld_ff  <= 1'b0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int i = 0; i < DIV_LAT; i++) begin
            side_vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         s1_vld_ff      <= req_valid;
         side_vld_ff[0] <= s1_vld_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_vld_ff[i] <= side_vld_ff[i-1];
         end
         e1_vld_ff  <= side_vld_ff[DIV_LAT-1];
         e2_vld_ff  <= e1_vld_ff;
         mg_vld_ff  <= e2_vld_ff;
         pp_vld_ff  <= mg_vld_ff;
         cm_vld_ff  <= pp_vld_ff;
         rd_vld_ff  <= cm_vld_ff;
         out_vld_ff <= rd_vld_ff;
      end
   end

   // Skid register: catches the output stage when the consumer is not ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (rsp_ready) skid_full_ff <= 1'b0;
      end else if (out_vld_ff && !rsp_ready) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_full_ff && out_vld_ff && !rsp_ready) begin
         skid_ff <= out_ff;
      end
   end

   assign rsp_valid   = skid_full_ff || out_vld_ff;
   assign rsp_payload = skid_full_ff ? skid_ff : out_ff;

   // The pipeline is frozen while the skid register holds a transaction.
   a_frozen_on_skid : assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |=> ($stable(out_ff) && $stable(out_vld_ff)))
      else $error("output stage changed while skid register was full");

   a_skid_load : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(out_vld_ff && !rsp_ready))
      else $error("skid register filled without a stalled transaction");

   a_invisible_zero : assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_ff.visible) |->
         (out_ff.clipped_start_x == '0 && out_ff.clipped_start_y == '0 &&
          out_ff.clipped_end_x == '0 && out_ff.clipped_end_y == '0))
      else $error("invisible line carries non-zero endpoints");

   a_segment_range : assert property (@(posedge clock) disable iff (reset)
      (e2_vld_ff && e2_ff.side.segment_mode) |->
         (e2_ff.es.t0 >= 0 && e2_ff.es.t1 <= T_ONE))
      else $error("segment parameter left the unit interval");

endmodule

`default_nettype wire
